// File: design/cftp_pkg.sv
// cftp_pkg: shared types and constants for the CAN frame text parser.
// No dependencies; used by cftp_front, cftp_queue, cftp_back and can_frame_text_parser.
package cftp_pkg;

    localparam int MAX_PAYLOAD = 8;
    localparam int CNT_W       = $clog2(MAX_PAYLOAD + 1);
    localparam int IDX_W       = 3;
    localparam int ID_W        = 11;
    localparam int NUM_W       = 32;

    localparam int Q_DEPTH     = 2;
    localparam int Q_PTR_W     = $clog2(Q_DEPTH);
    localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_ZERO = 3'd1;
    localparam logic [2:0] PH_DEC  = 3'd2;
    localparam logic [2:0] PH_HEX  = 3'd3;
    localparam logic [2:0] PH_BIN  = 3'd4;
    localparam logic [2:0] PH_STOP = 3'd5;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_ID_BIG   = 3'd1;
    localparam logic [2:0] ST_TOO_MANY = 3'd2;
    localparam logic [2:0] ST_BYTE_BIG = 3'd3;
    localparam logic [2:0] ST_NO_ID    = 3'd4;

    // classified character, front to back
    typedef struct packed {
        logic       term;
        logic       sep;
        logic       dec;
        logic       hexl;
        logic       xch;
        logic       bch;
        logic [3:0] digit;
    } t_cls;

endpackage

// File: design/cftp_byte_if.sv
// cftp_byte_if: valid/ready channel carrying one text byte per transaction.
// No dependencies.
interface cftp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;

    modport source (output valid, output text_byte, input ready);
    modport sink   (input valid, input text_byte, output ready);
endinterface

// File: design/cftp_frame_if.sv
// cftp_frame_if: valid/ready channel carrying one parsed frame per transaction.
// No dependencies.
interface cftp_frame_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [10:0] frame_id;
    logic [3:0]  byte_count;
    logic [7:0]  data_0;
    logic [7:0]  data_1;
    logic [7:0]  data_2;
    logic [7:0]  data_3;
    logic [7:0]  data_4;
    logic [7:0]  data_5;
    logic [7:0]  data_6;
    logic [7:0]  data_7;

    modport source (output valid, output status, output frame_id, output byte_count,
                    output data_0, output data_1, output data_2, output data_3,
                    output data_4, output data_5, output data_6, output data_7,
                    input ready);
    modport sink   (input valid, input status, input frame_id, input byte_count,
                    input data_0, input data_1, input data_2, input data_3,
                    input data_4, input data_5, input data_6, input data_7,
                    output ready);
endinterface

// File: design/cftp_front.sv
// cftp_front: accepts text bytes and classifies each into a t_cls token.
// Depends on cftp_pkg and cftp_byte_if.
module cftp_front (
    cftp_byte_if.sink      i_text,
    input  logic           i_q_ready,
    output logic           o_push,
    output cftp_pkg::t_cls o_cls
);

    logic [7:0] c;

    assign c             = i_text.text_byte;
    assign i_text.ready  = i_q_ready;
    assign o_push        = i_text.valid && i_q_ready;

    always_comb begin
        o_cls.term = (c == 8'h00);
        o_cls.sep  = (c >= 8'h01) && (c <= 8'h20);
        o_cls.dec  = (c >= 8'h30) && (c <= 8'h39);
        o_cls.hexl = ((c >= 8'h41) && (c <= 8'h46)) || ((c >= 8'h61) && (c <= 8'h66));
        o_cls.xch  = (c == 8'h78) || (c == 8'h58);
        o_cls.bch  = (c == 8'h62) || (c == 8'h42);
        if (o_cls.hexl) begin
            o_cls.digit = 4'(c[2:0]) + 4'd9;
        end else begin
            o_cls.digit = c[3:0];
        end
    end

endmodule

// File: design/cftp_queue.sv
// cftp_queue: short FIFO of classified tokens between front and back.
// Depends on cftp_pkg.
module cftp_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  cftp_pkg::t_cls i_cls,
    output logic           o_ready,
    input  logic           i_pop,
    output logic           o_valid,
    output cftp_pkg::t_cls o_cls
);

    cftp_pkg::t_cls                 r_mem [cftp_pkg::Q_DEPTH];
    logic [cftp_pkg::Q_PTR_W-1:0]   r_wr_ptr;
    logic [cftp_pkg::Q_PTR_W-1:0]   r_rd_ptr;
    logic [cftp_pkg::Q_CNT_W-1:0]   r_count;

    assign o_ready = (r_count != cftp_pkg::Q_CNT_W'(cftp_pkg::Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cls   = r_mem[r_rd_ptr];

    function automatic logic [cftp_pkg::Q_PTR_W-1:0] ptr_inc(
        input logic [cftp_pkg::Q_PTR_W-1:0] p);
        if (p == cftp_pkg::Q_PTR_W'(cftp_pkg::Q_DEPTH - 1)) begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cls;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// File: design/cftp_back.sv
// cftp_back: number scanner, frame assembly and result register.
// Depends on cftp_pkg and cftp_frame_if.
module cftp_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  cftp_pkg::t_cls i_cls,
    output logic           o_pop,
    cftp_frame_if.source   o_frame
);

    logic [2:0]                    r_phase, n_phase;
    logic [cftp_pkg::NUM_W-1:0]    r_num,   n_num;
    logic [cftp_pkg::ID_W-1:0]     r_id,    n_id;
    logic                          r_seen,  n_seen;
    logic [cftp_pkg::CNT_W-1:0]    r_cnt,   n_cnt;
    logic [7:0]                    r_pay [cftp_pkg::MAX_PAYLOAD];
    logic [7:0]                    n_pay [cftp_pkg::MAX_PAYLOAD];
    logic [2:0]                    r_err,   n_err;

    logic                          r_out_valid;
    logic [2:0]                    r_status,  n_status;
    logic [cftp_pkg::ID_W-1:0]     r_out_id;
    logic [cftp_pkg::CNT_W-1:0]    r_out_cnt;
    logic [7:0]                    r_out_data [cftp_pkg::MAX_PAYLOAD];

    logic                          end_num;
    logic                          restart;
    logic                          out_free;
    logic                          emit;

    assign out_free = !r_out_valid || o_frame.ready;
    assign o_pop    = i_valid && (!i_cls.term || out_free);
    assign emit     = o_pop && i_cls.term;

    always_comb begin
        n_phase = r_phase;
        n_num   = r_num;
        n_id    = r_id;
        n_seen  = r_seen;
        n_cnt   = r_cnt;
        n_pay   = r_pay;
        n_err   = r_err;
        end_num = 1'b0;
        restart = 1'b0;

        if (i_cls.term) begin
            end_num = (r_phase == cftp_pkg::PH_ZERO) || (r_phase == cftp_pkg::PH_DEC) ||
                      (r_phase == cftp_pkg::PH_HEX)  || (r_phase == cftp_pkg::PH_BIN);
        end else begin
            unique case (r_phase)
                cftp_pkg::PH_IDLE: begin
                    restart = 1'b1;
                end
                cftp_pkg::PH_ZERO: begin
                    priority if (i_cls.xch) begin
                        n_phase = cftp_pkg::PH_HEX;
                        n_num   = '0;
                    end else if (i_cls.bch) begin
                        n_phase = cftp_pkg::PH_BIN;
                        n_num   = '0;
                    end else if (i_cls.dec) begin
                        n_phase = cftp_pkg::PH_DEC;
                        n_num   = cftp_pkg::NUM_W'(i_cls.digit);
                    end else begin
                        end_num = 1'b1;
                        restart = 1'b1;
                    end
                end
                cftp_pkg::PH_DEC: begin
                    if (i_cls.dec) begin
                        n_num = (r_num << 3) + (r_num << 1) + cftp_pkg::NUM_W'(i_cls.digit);
                    end else begin
                        end_num = 1'b1;
                        restart = 1'b1;
                    end
                end
                cftp_pkg::PH_HEX: begin
                    if (i_cls.dec || i_cls.hexl) begin
                        n_num = {r_num[cftp_pkg::NUM_W-5:0], i_cls.digit};
                    end else begin
                        end_num = 1'b1;
                        restart = 1'b1;
                    end
                end
                cftp_pkg::PH_BIN: begin
                    if (i_cls.dec && (i_cls.digit[3:1] == 3'd0)) begin
                        n_num = {r_num[cftp_pkg::NUM_W-2:0], i_cls.digit[0]};
                    end else begin
                        end_num = 1'b1;
                        restart = 1'b1;
                    end
                end
                default: begin
                    n_phase = cftp_pkg::PH_STOP;
                end
            endcase
        end

        if (end_num) begin
            priority if (!r_seen) begin
                if (r_num[cftp_pkg::NUM_W-1:cftp_pkg::ID_W] != '0) begin
                    n_err = cftp_pkg::ST_ID_BIG;
                end else begin
                    n_id   = r_num[cftp_pkg::ID_W-1:0];
                    n_seen = 1'b1;
                end
            end else if (r_cnt >= cftp_pkg::CNT_W'(cftp_pkg::MAX_PAYLOAD)) begin
                n_err = cftp_pkg::ST_TOO_MANY;
            end else if (r_num[cftp_pkg::NUM_W-1:8] != '0) begin
                n_err = cftp_pkg::ST_BYTE_BIG;
            end else begin
                n_pay[r_cnt[cftp_pkg::IDX_W-1:0]] = r_num[7:0];
                n_cnt = r_cnt + 1'b1;
            end
            if (n_err != cftp_pkg::ST_OK) begin
                n_phase = cftp_pkg::PH_STOP;
            end
        end

        if (restart && (n_err == cftp_pkg::ST_OK)) begin
            priority if (i_cls.sep) begin
                n_phase = cftp_pkg::PH_IDLE;
            end else if (i_cls.dec && (i_cls.digit == 4'd0)) begin
                n_phase = cftp_pkg::PH_ZERO;
                n_num   = '0;
            end else if (i_cls.dec) begin
                n_phase = cftp_pkg::PH_DEC;
                n_num   = cftp_pkg::NUM_W'(i_cls.digit);
            end else begin
                n_phase = cftp_pkg::PH_STOP;
            end
        end

        priority if (n_err != cftp_pkg::ST_OK) begin
            n_status = n_err;
        end else if (!n_seen) begin
            n_status = cftp_pkg::ST_NO_ID;
        end else begin
            n_status = cftp_pkg::ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= cftp_pkg::PH_IDLE;
            r_num   <= '0;
            r_id    <= '0;
            r_seen  <= 1'b0;
            r_cnt   <= '0;
            r_err   <= cftp_pkg::ST_OK;
            for (int k = 0; k < cftp_pkg::MAX_PAYLOAD; k++) begin
                r_pay[k] <= '0;
            end
        end else if (emit) begin
            // line done: back to the cleared state
            r_phase <= cftp_pkg::PH_IDLE;
            r_num   <= '0;
            r_id    <= '0;
            r_seen  <= 1'b0;
            r_cnt   <= '0;
            r_err   <= cftp_pkg::ST_OK;
            for (int k = 0; k < cftp_pkg::MAX_PAYLOAD; k++) begin
                r_pay[k] <= '0;
            end
        end else if (o_pop) begin
            r_phase <= n_phase;
            r_num   <= n_num;
            r_id    <= n_id;
            r_seen  <= n_seen;
            r_cnt   <= n_cnt;
            r_err   <= n_err;
            r_pay   <= n_pay;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (o_frame.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_status <= n_status;
            if (n_status == cftp_pkg::ST_OK) begin
                r_out_id  <= n_id;
                r_out_cnt <= n_cnt;
                r_out_data <= n_pay;
            end else begin
                r_out_id  <= '0;
                r_out_cnt <= '0;
                for (int k = 0; k < cftp_pkg::MAX_PAYLOAD; k++) begin
                    r_out_data[k] <= '0;
                end
            end
        end
    end

    assign o_frame.valid      = r_out_valid;
    assign o_frame.status     = r_status;
    assign o_frame.frame_id   = r_out_id;
    assign o_frame.byte_count = r_out_cnt;
    assign o_frame.data_0     = r_out_data[0];
    assign o_frame.data_1     = r_out_data[1];
    assign o_frame.data_2     = r_out_data[2];
    assign o_frame.data_3     = r_out_data[3];
    assign o_frame.data_4     = r_out_data[4];
    assign o_frame.data_5     = r_out_data[5];
    assign o_frame.data_6     = r_out_data[6];
    assign o_frame.data_7     = r_out_data[7];

    a_line_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |=> (r_phase == cftp_pkg::PH_IDLE) && (r_cnt == '0) && !r_seen && r_out_valid)
        else $error("scanner state not cleared after terminator");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= cftp_pkg::CNT_W'(cftp_pkg::MAX_PAYLOAD))
        else $error("byte count beyond payload size");

    a_err_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_err != cftp_pkg::ST_OK) |-> (r_phase == cftp_pkg::PH_STOP))
        else $error("error raised but scanner not stopped");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_frame.ready) |-> !emit)
        else $error("result register overwritten while held");

endmodule

// File: design/can_frame_text_parser.sv
// can_frame_text_parser: one text byte per cycle in when not stalled, one frame result per line out.
// Result path: a terminator passes the token queue, then cftp_back registers its result.
// Throughput: one byte per cycle; a result waiting in the output register stalls the
// next terminator, and the bytes behind it fill the two-entry token queue, then the input.
// Reset: synchronous active-low i_rst_n clears scanner, queue and output valid.
// Depends on cftp_pkg, cftp_byte_if, cftp_frame_if, cftp_front, cftp_queue, cftp_back.
module can_frame_text_parser (
    input  logic         i_clk,
    input  logic         i_rst_n,
    cftp_byte_if.sink    i_text,
    cftp_frame_if.source o_frame
);

    logic           push;
    logic           q_ready;
    logic           q_valid;
    logic           pop;
    cftp_pkg::t_cls front_cls;
    cftp_pkg::t_cls q_cls;

    cftp_front u_front (
        .i_text    (i_text),
        .i_q_ready (q_ready),
        .o_push    (push),
        .o_cls     (front_cls)
    );

    cftp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cls   (front_cls),
        .o_ready (q_ready),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_cls   (q_cls)
    );

    cftp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_cls   (q_cls),
        .o_pop   (pop),
        .o_frame (o_frame)
    );

endmodule

// File: tb/can_frame_text_parser_tb.sv
`timescale 1ns / 100ps
// can_frame_text_parser_tb: self-checking bench; feeds command text byte by byte and checks
// each parsed frame against an in-bench line parser. Depends on cftp_pkg, cftp_byte_if,
// cftp_frame_if and can_frame_text_parser.
module can_frame_text_parser_tb;

    localparam int QUIET_LIMIT = 3000;
    localparam int HOLD_CYCLES = 400;

    typedef enum int {RADIX_DEC, RADIX_HEX, RADIX_BIN} t_radix;

    typedef struct packed {
        logic [2:0]      status;
        logic [10:0]     frame_id;
        logic [3:0]      byte_count;
        logic [7:0][7:0] data;
    } t_frame_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic send_valid = 1'b0;
    logic [7:0] send_byte = 8'h00;
    logic take_ready = 1'b0;

    cftp_byte_if  text_ch ();
    cftp_frame_if frame_ch ();

    assign text_ch.valid     = send_valid;
    assign text_ch.text_byte = send_byte;
    assign frame_ch.ready    = take_ready;

    can_frame_text_parser dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_text  (text_ch.sink),
        .o_frame (frame_ch.source)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    logic [7:0]      text_pending [$];
    t_frame_result   frames_due [$];
    int              bytes_queued = 0;
    int              bytes_accepted = 0;
    int              error_count = 0;

    // line parser state
    logic [2:0]      ln_phase;
    logic [31:0]     ln_value;
    logic [10:0]     ln_id;
    logic            ln_id_seen;
    logic [3:0]      ln_count;
    logic [7:0][7:0] ln_data;
    logic [2:0]      ln_error;

    function automatic bit is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic void clear_line_state();
        ln_phase   = cftp_pkg::PH_IDLE;
        ln_value   = '0;
        ln_id      = '0;
        ln_id_seen = 1'b0;
        ln_count   = '0;
        ln_data    = '0;
        ln_error   = cftp_pkg::ST_OK;
    endfunction

    function automatic void close_number(logic [31:0] v);
        if (!ln_id_seen) begin
            if (v > 32'h7ff) begin
                ln_error = cftp_pkg::ST_ID_BIG;
            end else begin
                ln_id      = v[10:0];
                ln_id_seen = 1'b1;
            end
        end else if (ln_count >= cftp_pkg::MAX_PAYLOAD) begin
            ln_error = cftp_pkg::ST_TOO_MANY;
        end else if (v > 32'hff) begin
            ln_error = cftp_pkg::ST_BYTE_BIG;
        end else begin
            ln_data[ln_count[2:0]] = v[7:0];
            ln_count = ln_count + 4'd1;
        end
        if (ln_error != cftp_pkg::ST_OK) ln_phase = cftp_pkg::PH_STOP;
    endfunction

    function automatic void start_token(logic [7:0] c);
        if (c >= 8'd1 && c <= 8'd32) begin
            ln_phase = cftp_pkg::PH_IDLE;
        end else if (c == "0") begin
            ln_phase = cftp_pkg::PH_ZERO;
            ln_value = '0;
        end else if (is_digit(c)) begin
            ln_phase = cftp_pkg::PH_DEC;
            ln_value = 32'(c - "0");
        end else begin
            ln_phase = cftp_pkg::PH_STOP;
        end
    endfunction

    // the byte that ends a number is then treated as if it came between numbers
    function automatic void end_and_restart(logic [7:0] c);
        close_number(ln_value);
        if (ln_error == cftp_pkg::ST_OK) start_token(c);
    endfunction

    function automatic void parse_text_byte(logic [7:0] c);
        t_frame_result res;
        if (c == 8'd0) begin
            if (ln_phase == cftp_pkg::PH_ZERO || ln_phase == cftp_pkg::PH_DEC ||
                ln_phase == cftp_pkg::PH_HEX || ln_phase == cftp_pkg::PH_BIN)
                close_number(ln_value);
            if (ln_error != cftp_pkg::ST_OK)
                res.status = ln_error;
            else if (!ln_id_seen)
                res.status = cftp_pkg::ST_NO_ID;
            else
                res.status = cftp_pkg::ST_OK;
            res.frame_id   = (res.status == cftp_pkg::ST_OK) ? ln_id : 11'd0;
            res.byte_count = (res.status == cftp_pkg::ST_OK) ? ln_count : 4'd0;
            for (int k = 0; k < 8; k++)
                res.data[k] = (res.status == cftp_pkg::ST_OK && k < ln_count) ?
                              ln_data[k] : 8'd0;
            frames_due.push_back(res);
            clear_line_state();
        end else begin
            case (ln_phase)
                cftp_pkg::PH_IDLE: start_token(c);
                cftp_pkg::PH_ZERO: begin
                    if (c == "x" || c == "X") begin
                        ln_phase = cftp_pkg::PH_HEX;
                        ln_value = '0;
                    end else if (c == "b" || c == "B") begin
                        ln_phase = cftp_pkg::PH_BIN;
                        ln_value = '0;
                    end else if (is_digit(c)) begin
                        ln_phase = cftp_pkg::PH_DEC;
                        ln_value = 32'(c - "0");
                    end else begin
                        end_and_restart(c);
                    end
                end
                cftp_pkg::PH_DEC: begin
                    if (is_digit(c)) ln_value = ln_value * 10 + 32'(c - "0");
                    else end_and_restart(c);
                end
                cftp_pkg::PH_HEX: begin
                    if (is_digit(c)) ln_value = (ln_value << 4) + 32'(c - "0");
                    else if (c >= "A" && c <= "F")
                        ln_value = (ln_value << 4) + 32'(c - "A") + 32'd10;
                    else if (c >= "a" && c <= "f")
                        ln_value = (ln_value << 4) + 32'(c - "a") + 32'd10;
                    else end_and_restart(c);
                end
                cftp_pkg::PH_BIN: begin
                    if (c == "0" || c == "1") ln_value = {ln_value[30:0], c[0]};
                    else end_and_restart(c);
                end
                default: ln_phase = cftp_pkg::PH_STOP;
            endcase
        end
    endfunction

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 15);
        return $urandom_range(20, 80);
    endfunction

    // driver
    int send_gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            send_valid <= 1'b0;
            send_gap   <= 0;
            clear_line_state();
        end else begin
            if (send_valid && text_ch.ready) begin
                parse_text_byte(send_byte);
                bytes_accepted++;
            end
            if (!send_valid || text_ch.ready) begin
                if (send_gap > 0) begin
                    send_valid <= 1'b0;
                    send_gap   <= send_gap - 1;
                end else if (text_pending.size() > 0) begin
                    send_valid <= 1'b1;
                    send_byte  <= text_pending.pop_front();
                    send_gap   <= idle_len();
                end else begin
                    send_valid <= 1'b0;
                end
            end
        end
    end

    // receiver ready, with two long hold-offs to back the block up
    int hold_cnt = 0;
    int stall_cnt = 0;
    int results_seen = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            take_ready   <= 1'b0;
            hold_cnt     <= 0;
            stall_cnt    <= 0;
            results_seen <= 0;
        end else begin
            if (frame_ch.valid && take_ready) results_seen <= results_seen + 1;
            if (hold_cnt > 0) begin
                take_ready <= 1'b0;
                hold_cnt   <= hold_cnt - 1;
            end else if (frame_ch.valid && take_ready &&
                         (results_seen == 9 || results_seen == 49)) begin
                take_ready <= 1'b0;
                hold_cnt   <= HOLD_CYCLES;
            end else if (stall_cnt > 0) begin
                take_ready <= 1'b0;
                stall_cnt  <= stall_cnt - 1;
            end else begin
                take_ready <= 1'b1;
                stall_cnt  <= ($urandom_range(0, 4) == 0) ? idle_len() : 0;
            end
        end
    end

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            error_count++;
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    // monitor
    always @(posedge i_clk) begin
        t_frame_result   want;
        logic [7:0][7:0] got_data;
        if (i_rst_n && frame_ch.valid && take_ready) begin
            got_data = {frame_ch.data_7, frame_ch.data_6, frame_ch.data_5, frame_ch.data_4,
                        frame_ch.data_3, frame_ch.data_2, frame_ch.data_1, frame_ch.data_0};
            if (frames_due.size() == 0) begin
                error_count++;
                $display("%0t: unexpected frame, status %0d id %0d", $time,
                         frame_ch.status, frame_ch.frame_id);
            end else begin
                want = frames_due.pop_front();
                check_field("status", 32'(want.status), 32'(frame_ch.status));
                check_field("frame_id", 32'(want.frame_id), 32'(frame_ch.frame_id));
                check_field("byte_count", 32'(want.byte_count), 32'(frame_ch.byte_count));
                for (int k = 0; k < 8; k++)
                    check_field($sformatf("data_%0d", k), 32'(want.data[k]),
                                32'(got_data[k]));
            end
        end
    end

    // watchdog
    int quiet_cycles = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n || (send_valid && text_ch.ready) || (frame_ch.valid && take_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
            $display("can_frame_text_parser_tb NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic put_byte(logic [7:0] b);
        text_pending.push_back(b);
        bytes_queued++;
    endtask

    task automatic put_text(string s);
        for (int i = 0; i < s.len(); i++) put_byte(s[i]);
    endtask

    task automatic put_line_text(string s);
        put_text(s);
        put_byte(8'd0);
    endtask

    task automatic put_separators();
        repeat ($urandom_range(1, 2))
            put_byte(($urandom_range(0, 9) < 7) ? 8'd32 : 8'($urandom_range(1, 32)));
    endtask

    function automatic logic [7:0] stop_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(33, 255)); while (is_digit(b));
        return b;
    endfunction

    task automatic put_number(logic [31:0] v, t_radix radix, bit allow_pad);
        string      digits;
        int         pad;
        logic [7:0] ch;
        pad = (allow_pad && $urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 0;
        case (radix)
            RADIX_DEC: digits = $sformatf("%0d", v);
            RADIX_HEX: begin
                put_byte("0");
                put_byte($urandom_range(0, 1) ? "x" : "X");
                digits = $sformatf("%0h", v);
            end
            default: begin
                put_byte("0");
                put_byte($urandom_range(0, 1) ? "b" : "B");
                digits = $sformatf("%0b", v);
            end
        endcase
        if (radix != RADIX_DEC && v == 0 && $urandom_range(0, 2) == 0) digits = "";
        repeat (pad) put_byte("0");
        for (int i = 0; i < digits.len(); i++) begin
            ch = digits[i];
            if (ch >= "a" && ch <= "f" && $urandom_range(0, 1)) ch = ch - 8'h20;
            put_byte(ch);
        end
    endtask

    function automatic t_radix pick_radix();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5) return RADIX_DEC;
        if (r < 8) return RADIX_HEX;
        return RADIX_BIN;
    endfunction

    function automatic logic [31:0] id_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 90) return $urandom_range(0, 2047);
        if (r < 95) return $urandom_range(2048, 4095);
        return $urandom();
    endfunction

    function automatic logic [31:0] data_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 88) return $urandom_range(0, 255);
        if (r < 94) return $urandom_range(256, 65535);
        return $urandom();
    endfunction

    // mostly well-formed lines; some break off into junk, a few are pure noise
    task automatic put_random_line();
        int          shape;
        int          n_data;
        t_radix      radix;
        t_radix      prev_radix;
        logic [31:0] v;
        string       head;
        bit          shared;
        shape = $urandom_range(0, 99);
        if (shape >= 92) begin
            repeat ($urandom_range(1, 16)) put_byte(8'($urandom_range(1, 255)));
        end else begin
            if ($urandom_range(0, 3) == 0) put_separators();
            n_data = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 10) : $urandom_range(0, 8);
            prev_radix = RADIX_DEC;
            for (int k = 0; k <= n_data; k++) begin
                v      = (k == 0) ? id_value() : data_value();
                radix  = pick_radix();
                shared = 1'b0;
                if (k > 0) begin
                    head = $sformatf("%0d", v);
                    shared = prev_radix == RADIX_BIN && radix == RADIX_DEC &&
                             head[0] >= "2" && $urandom_range(0, 1);
                    if (!shared) put_separators();
                end
                put_number(v, radix, !shared);
                prev_radix = radix;
                if (shape >= 78 && $urandom_range(0, n_data) == 0) begin
                    put_byte(stop_byte());
                    repeat ($urandom_range(0, 6)) put_byte(8'($urandom_range(1, 255)));
                    break;
                end
            end
            if ($urandom_range(0, 3) == 0) put_separators();
        end
        put_byte(8'd0);
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        put_line_text("");
        put_line_text("0x7FF 255 0xff 0b11111111 0XFf 0B1 9 0 128");
        put_line_text("2048");
        put_line_text("1 2 3 4 5 6 7 8 9 10");
        put_line_text("5 256");
        put_line_text("12 1 2 3 4 5 6 7 8 300");
        put_line_text("0x 0b 0X 0B");
        put_line_text("007 08 00");
        put_line_text("0b1015");
        put_line_text("12,34");
        put_line_text("99999999999");
        put_line_text("0x100000123 0x100000012");
        put_line_text("4096 1 2 x 7");
        put_byte(8'd255);
        put_line_text(" 1 2");
        put_byte(8'd1);
        put_text("7\t");
        put_byte(8'd32);
        put_line_text("0xaB");
        put_line_text("0xFFFFFFFF");
        put_line_text("1 0b11111111111111111111111111111111");
        put_line_text("3 0x");
        put_line_text("0 0");
        put_line_text("12a 5");
        put_line_text("0b2");
        put_line_text("0x1g");
        put_line_text("0z 4");
        put_text("1 2");
        put_byte(8'd127);
        put_line_text(" 3");

        // sender pause: let every outstanding frame drain
        while (bytes_accepted != bytes_queued || frames_due.size() != 0) @(posedge i_clk);

        while (bytes_queued < 1100) begin
            put_random_line();
        end

        while (bytes_accepted != bytes_queued || frames_due.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (error_count == 0)
            $display("can_frame_text_parser_tb OK");
        else
            $display("can_frame_text_parser_tb NOT OK");
        $finish;
    end
endmodule
